### src/eesc_pkg.sv
package eesc_pkg;

   localparam int DEPTH_BITS         = 8;
   localparam int LITERAL_DEPTH_BITS = 8;
   localparam int LENGTH_BITS        = 16;
   localparam int TOKEN_LENGTH_BITS  = 16;

   localparam logic [TOKEN_LENGTH_BITS-1:0] TOKEN_LENGTH_MAX = '1;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_BACKTICK  = 8'h60;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;

   typedef enum logic [1:0] {
      STATUS_SCANNING = 2'd0,
      STATUS_TOKEN    = 2'd1,
      STATUS_NO_TOKEN = 2'd2,
      STATUS_IDLE     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      MODE_NORMAL         = 3'd0,
      MODE_QUOTED         = 3'd1,
      MODE_QUOTED_ESC     = 3'd2,
      MODE_LITERAL        = 3'd3,
      MODE_LITERAL_ESC    = 3'd4,
      MODE_LITERAL_DOLLAR = 3'd5
   } mode_type;

   typedef struct packed {
      mode_type                      mode;
      logic                          quote_double;
      logic [DEPTH_BITS-1:0]         brace_depth;
      logic [LITERAL_DEPTH_BITS-1:0] literal_depth;
      logic [LENGTH_BITS-1:0]        consumed;
      logic                          finished;
      logic                          overflow;
   } scan_state_type;

   typedef struct packed {
      status_type                   status;
      logic [TOKEN_LENGTH_BITS-1:0] token_length;
      logic                         depth_overflow;
   } scan_result_type;

   localparam scan_state_type SCAN_STATE_CLEAR = '{
      mode:          MODE_NORMAL,
      quote_double:  1'b0,
      brace_depth:   '0,
      literal_depth: '0,
      consumed:      '0,
      finished:      1'b0,
      overflow:      1'b0
   };

endpackage

### src/eesc_step.sv
module eesc_step (
   input  eesc_pkg::scan_state_type  cur_state,
   input  logic                      start_scan,
   input  logic                      end_of_input,
   input  logic [7:0]                char_code,
   output eesc_pkg::scan_state_type  nxt_state,
   output eesc_pkg::scan_result_type result
);
   import eesc_pkg::*;

   always_comb begin
      scan_state_type s;
      status_type     status;
      logic           do_consume;
      logic           lit_char;
      logic [7:0]     quote_ch;

      s          = start_scan ? SCAN_STATE_CLEAR : cur_state;
      status     = STATUS_SCANNING;
      do_consume = 1'b0;
      lit_char   = 1'b0;
      quote_ch   = s.quote_double ? CH_DQUOTE : CH_SQUOTE;

      if (s.finished) begin
         status = STATUS_IDLE;
      end else if (end_of_input || char_code == CH_NUL) begin
         s.finished = 1'b1;
         status     = STATUS_NO_TOKEN;
      end else begin
         unique case (s.mode)
            MODE_QUOTED: begin
               if (char_code == quote_ch) begin
                  s.mode = MODE_NORMAL;
               end else if (char_code == CH_BACKSLASH) begin
                  s.mode = MODE_QUOTED_ESC;
               end
               do_consume = 1'b1;
            end
            MODE_QUOTED_ESC: begin
               s.mode     = MODE_QUOTED;
               do_consume = 1'b1;
            end
            MODE_LITERAL: begin
               lit_char = 1'b1;
            end
            MODE_LITERAL_ESC: begin
               s.mode     = MODE_LITERAL;
               do_consume = 1'b1;
            end
            MODE_LITERAL_DOLLAR: begin
               s.mode = MODE_LITERAL;
               if (char_code == CH_LBRACE) begin
                  if (s.literal_depth != '1) begin
                     s.literal_depth = s.literal_depth + 1'b1;
                  end else begin
                     s.overflow = 1'b1;
                  end
                  do_consume = 1'b1;
               end else begin
                  lit_char = 1'b1;
               end
            end
            default: begin
               s.mode = MODE_NORMAL;
               if (char_code == CH_RBRACE && s.brace_depth == '0) begin
                  s.finished = 1'b1;
                  status     = (s.consumed != '0) ? STATUS_TOKEN : STATUS_NO_TOKEN;
               end else begin
                  if (char_code == CH_RBRACE) begin
                     s.brace_depth = s.brace_depth - 1'b1;
                  end else if (char_code == CH_LBRACE) begin
                     if (s.brace_depth != '1) begin
                        s.brace_depth = s.brace_depth + 1'b1;
                     end else begin
                        s.overflow = 1'b1;
                     end
                  end else if (char_code == CH_SQUOTE || char_code == CH_DQUOTE) begin
                     s.quote_double = (char_code == CH_DQUOTE);
                     s.mode         = MODE_QUOTED;
                  end else if (char_code == CH_BACKTICK) begin
                     s.literal_depth = '0;
                     s.mode          = MODE_LITERAL;
                  end
                  do_consume = 1'b1;
               end
            end
         endcase

         if (lit_char) begin
            priority if (char_code == CH_BACKSLASH) begin
               s.mode = MODE_LITERAL_ESC;
            end else if (char_code == CH_DOLLAR) begin
               s.mode = MODE_LITERAL_DOLLAR;
            end else if (char_code == CH_RBRACE && s.literal_depth != '0) begin
               s.literal_depth = s.literal_depth - 1'b1;
            end else if (char_code == CH_BACKTICK && s.literal_depth == '0) begin
               s.mode = MODE_NORMAL;
            end else begin
               s.mode = MODE_LITERAL;
            end
            do_consume = 1'b1;
         end
      end

      if (do_consume && s.consumed != '1) begin
         s.consumed = s.consumed + 1'b1;
      end

      nxt_state             = s;
      result.status         = status;
      result.token_length   = (s.consumed > LENGTH_BITS'(TOKEN_LENGTH_MAX)) ?
                              TOKEN_LENGTH_MAX : TOKEN_LENGTH_BITS'(s.consumed);
      result.depth_overflow = s.overflow;
   end

endmodule

### src/embedded_expression_end_scanner_core.sv
// Embedded expression end scanner.
// Request channel (req_valid/req_ready): one character per request, with
// req_start_scan to begin a new scan and req_end_of_input to close it
// (a NUL character also closes it). Response channel (rsp_valid/rsp_ready):
// exactly one response per request, in order: rsp_status (scanning, token
// ends before this brace, no token, idle after finish), rsp_token_length
// (characters consumed, saturating) and rsp_depth_overflow.
// Path: an accepted request is held in the request register, then its
// response in the response register (two registers).
// Throughput: one request per cycle while responses are taken; the scan
// state update is combinational logic between the two registers.
// A stalled response holds its register; the request register still takes
// one more request, then req_ready drops until the response is taken.
// Reset (synchronous, active high) clears the scan state and empties both
// registers.
module embedded_expression_end_scanner_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_start_scan,
   input  logic                                 req_end_of_input,
   input  logic [7:0]                           req_char_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [eesc_pkg::TOKEN_LENGTH_BITS-1:0] rsp_token_length,
   output logic                                 rsp_depth_overflow
);
   import eesc_pkg::*;

   logic            in_valid_ff;
   logic            in_start_ff;
   logic            in_eoi_ff;
   logic [7:0]      in_char_ff;
   scan_state_type  state_ff;
   scan_state_type  state_in;
   scan_result_type result_in;
   scan_result_type result_ff;
   logic            out_valid_ff;
   logic            step_go;

   assign step_go   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_go;

   eesc_step u_step (
      .cur_state    (state_ff),
      .start_scan   (in_start_ff),
      .end_of_input (in_eoi_ff),
      .char_code    (in_char_ff),
      .nxt_state    (state_in),
      .result       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= SCAN_STATE_CLEAR;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (step_go) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_start_ff <= req_start_scan;
         in_eoi_ff   <= req_end_of_input;
         in_char_ff  <= req_char_code;
      end
      if (step_go) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = result_ff.status;
   assign rsp_token_length   = result_ff.token_length;
   assign rsp_depth_overflow = result_ff.depth_overflow;

endmodule
